### rtl/wsfrt_pkg.sv
// shared constants, types and helpers of the fragment reassembly tracker
package wsfrt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_WIDTH   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CAP_WIDTH-1:0] CAP_RESET   = CAP_WIDTH'(4096);
    localparam logic [3:0]           TEXT_OPCODE = 4'h1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        STATUS_READY = 2'd0,
        STATUS_MORE  = 2'd1,
        STATUS_DROP  = 2'd2
    } status_t;

    // classified chunk handed from the front end to the back end
    typedef struct packed {
        logic        non_text;
        logic        bad;
        logic        whole;
        logic        start;
        logic        plen_big;
        logic        len_big;
        logic        off_fits;
        count_t      off_low;
        count_t      len_low;
        count_t      plen_low;
        logic [30:0] len_ready;
    } chunk_class_t;

    // capacity in use, saturated to what the counters can hold
    function automatic count_t sat_cap(input logic [CAP_WIDTH-1:0] cap);
        logic [32:0] wide;
        begin
            wide = 33'(cap);
            if (wide > 33'(COUNT_MAX))
                sat_cap = COUNT_MAX;
            else
                sat_cap = count_t'(cap);
        end
    endfunction

endpackage

### rtl/wsfrt_if.sv
// channel interfaces for chunk descriptors and tracker results
interface wsfrt_chunk_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic signed [31:0] chunk_offset;
    logic signed [31:0] chunk_length;
    logic signed [31:0] message_length;
    logic        data_present;

    modport source (output valid, output opcode, output chunk_offset,
                    output chunk_length, output message_length,
                    output data_present, input ready);
    modport sink   (input valid, input opcode, input chunk_offset,
                    input chunk_length, input message_length,
                    input data_present, output ready);
endinterface

interface wsfrt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        from_buffer;
    logic [30:0] ready_length;
    logic        append_enable;
    logic [15:0] append_offset;

    modport source (output valid, output status, output from_buffer,
                    output ready_length, output append_enable,
                    output append_offset, input ready);
    modport sink   (input valid, input status, input from_buffer,
                    input ready_length, input append_enable,
                    input append_offset, output ready);
endinterface

### rtl/websocket_fragment_reassembly_tracker_unit.sv
// top level of the text-message fragment reassembly tracker
//
//  port       dir   handshake               carries
//  chunk      in    valid/ready             opcode, offset, lengths, data flag
//  result     out   valid/ready             status, from_buffer, length, append
//  cfg_we     in    write enable, no wait   cfg_wdata -> buffer_capacity
//
// one chunk per cycle sustained while results are taken; a result passes the classify
// register, a queue entry and the result register, in that order, before it is offered
// the counter update in the back end is a single add and compare per cycle
// rst_n clears the counters and all valid flags; capacity returns to 4096
// a stalled result holds the back end, the queue and the classify register then absorb
// three chunks before chunk.ready drops
module websocket_fragment_reassembly_tracker_unit
    import wsfrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    wsfrt_chunk_if.sink           chunk,
    wsfrt_result_if.source        result,
    input  logic                  cfg_we,
    input  logic [CAP_WIDTH-1:0]  cfg_wdata
);

    logic [CAP_WIDTH-1:0] capacity_reg;
    count_t               cap_eff;

    logic         f_valid;
    logic         f_ready;
    chunk_class_t f_data;
    logic         q_valid;
    logic         q_ready;
    chunk_class_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    assign cap_eff = sat_cap(capacity_reg);

    wsfrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chunk     (chunk),
        .cap_eff   (cap_eff),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_data  (f_data)
    );

    wsfrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    wsfrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls_data  (q_data),
        .cap_eff   (cap_eff),
        .result    (result)
    );

endmodule

### rtl/wsfrt_front.sv
// front end: accepts chunk descriptors and classifies them into one register stage
module wsfrt_front
    import wsfrt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wsfrt_chunk_if.sink   chunk,
    input  count_t        cap_eff,
    output logic          cls_valid,
    input  logic          cls_ready,
    output chunk_class_t  cls_data
);

    logic         stage_valid_reg;
    logic         stage_valid_next;
    chunk_class_t stage_reg;
    chunk_class_t cls_comb;

    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] plen;
    logic [32:0] end_pos;
    logic        take;

    assign off  = chunk.chunk_offset;
    assign len  = chunk.chunk_length;
    assign plen = chunk.message_length;
    // operands are non-negative whenever this matters, so a 33-bit unsigned sum is exact
    assign end_pos = 33'(off) + 33'(len);

    always_comb
    begin
        cls_comb.non_text  = (chunk.opcode != TEXT_OPCODE);
        cls_comb.bad       = off[31] || len[31] || plen[31] || !chunk.data_present
                             || (len == 32'd0) || (end_pos > 33'(plen));
        cls_comb.whole     = (off == 32'd0) && (len == plen);
        cls_comb.start     = (off == 32'd0);
        cls_comb.plen_big  = plen > 32'(cap_eff);
        cls_comb.len_big   = len > 32'(cap_eff);
        cls_comb.off_fits  = off <= 32'(COUNT_MAX);
        cls_comb.off_low   = count_t'(off);
        cls_comb.len_low   = count_t'(len);
        cls_comb.plen_low  = count_t'(plen);
        cls_comb.len_ready = len[30:0];
    end

    assign chunk.ready = !stage_valid_reg || cls_ready;
    assign take        = chunk.valid && chunk.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
            stage_valid_next = 1'b1;
        else if (cls_ready)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= cls_comb;
    end

    assign cls_valid = stage_valid_reg;
    assign cls_data  = stage_reg;

endmodule

### rtl/wsfrt_queue.sv
// short queue of classified chunks between front and back ends
module wsfrt_queue
    import wsfrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  chunk_class_t push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output chunk_class_t pop_data
);

    chunk_class_t mem [QUEUE_DEPTH];

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        begin
            if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                ptr_inc = '0;
            else
                ptr_inc = p + QUEUE_PTR_W'(1);
        end
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/wsfrt_back.sv
// back end: applies classified chunks to the message counters and registers the result
module wsfrt_back
    import wsfrt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cls_valid,
    output logic           cls_ready,
    input  chunk_class_t   cls_data,
    input  count_t         cap_eff,
    wsfrt_result_if.source result
);

    count_t  expected_reg, expected_next;
    count_t  written_reg, written_next;
    logic    out_valid_reg, out_valid_next;

    status_t     status_reg, status_next;
    logic        from_buffer_reg, from_buffer_next;
    logic [30:0] ready_length_reg, ready_length_next;
    logic        append_enable_reg, append_enable_next;
    logic [15:0] append_offset_reg, append_offset_next;

    logic                 pop;
    count_t               base;
    logic [COUNT_WIDTH:0] sum;
    count_t               sum_low;

    assign cls_ready = !out_valid_reg || result.ready;
    assign pop       = cls_valid && cls_ready;

    // a new start rewinds the write position to zero
    assign base    = cls_data.start ? '0 : written_reg;
    assign sum     = {1'b0, base} + {1'b0, cls_data.len_low};
    assign sum_low = sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        expected_next      = expected_reg;
        written_next       = written_reg;
        status_next        = STATUS_DROP;
        from_buffer_next   = 1'b0;
        ready_length_next  = '0;
        append_enable_next = 1'b0;
        append_offset_next = '0;

        if (cls_data.non_text)
        begin
            // dropped, counters untouched
        end
        else if (cls_data.bad)
        begin
            expected_next = '0;
            written_next  = '0;
        end
        else if (cls_data.whole && expected_reg == '0)
        begin
            status_next       = STATUS_READY;
            ready_length_next = cls_data.len_ready;
        end
        else if ((cls_data.start && cls_data.plen_big)
                 || (!cls_data.start && (expected_reg == '0 || !cls_data.off_fits
                                         || cls_data.off_low != written_reg))
                 || cls_data.len_big || sum > {1'b0, cap_eff})
        begin
            expected_next = '0;
            written_next  = '0;
        end
        else
        begin
            append_enable_next = 1'b1;
            append_offset_next = 16'(base);
            if (sum_low < (cls_data.start ? cls_data.plen_low : expected_reg))
            begin
                status_next   = STATUS_MORE;
                expected_next = cls_data.start ? cls_data.plen_low : expected_reg;
                written_next  = sum_low;
            end
            else
            begin
                status_next       = STATUS_READY;
                from_buffer_next  = 1'b1;
                ready_length_next = 31'(sum_low);
                expected_next     = '0;
                written_next      = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                expected_reg <= expected_next;
                written_reg  <= written_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg        <= status_next;
            from_buffer_reg   <= from_buffer_next;
            ready_length_reg  <= ready_length_next;
            append_enable_reg <= append_enable_next;
            append_offset_reg <= append_offset_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = status_reg;
    assign result.from_buffer   = from_buffer_reg;
    assign result.ready_length  = ready_length_reg;
    assign result.append_enable = append_enable_reg;
    assign result.append_offset = append_offset_reg;

endmodule

### rtl/wsfrt_checker.sv
// port-level checks on the tracker's result channel, bound to the top level
module wsfrt_checker
    import wsfrt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  status,
    input logic        from_buffer,
    input logic [30:0] ready_length,
    input logic        append_enable,
    input logic [15:0] append_offset
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // anything but ready carries no length and no buffer flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STATUS_READY |-> ready_length == '0 && !from_buffer)
        else $error("length or buffer flag on a non-ready result");

    // no append means no append position
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !append_enable |-> append_offset == '0)
        else $error("append offset without append");

    // need-more and buffered completion both come from an appended chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STATUS_MORE || from_buffer) |-> append_enable)
        else $error("progress reported without an append");

    // a buffered completion is always a ready result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && from_buffer |-> status == STATUS_READY)
        else $error("buffer flag on a non-ready status");

endmodule

bind websocket_fragment_reassembly_tracker_unit wsfrt_checker u_wsfrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .status        (result.status),
    .from_buffer   (result.from_buffer),
    .ready_length  (result.ready_length),
    .append_enable (result.append_enable),
    .append_offset (result.append_offset)
);

### tb/sv/tb.sv
// self-checking testbench of the fragment reassembly tracker with driver, monitor and predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsfrt_pkg::*;

    typedef struct {
        logic [3:0]         opcode;
        logic signed [31:0] offset;
        logic signed [31:0] length;
        logic signed [31:0] msg_len;
        logic               data;
    } chunk_t;

    typedef struct packed {
        status_t     status;
        logic        from_buffer;
        logic [30:0] ready_length;
        logic        append_enable;
        logic [15:0] append_offset;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CAP_WIDTH-1:0] cfg_wdata;

    wsfrt_chunk_if  chunk_ch ();
    wsfrt_result_if result_ch ();

    websocket_fragment_reassembly_tracker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chunk     (chunk_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    chunk_t   chunk_q[$];
    outcome_t outcome_q[$];

    // tracker state as predicted
    count_t               msg_expected;
    count_t               msg_written;
    logic [CAP_WIDTH-1:0] capacity_model;

    int mismatches    = 0;
    int items_queued  = 0;
    int src_idle_pct  = 10;
    int snk_idle_pct  = 10;
    int src_gap;
    int snk_gap;

    function automatic outcome_t track_chunk(input chunk_t c);
        outcome_t o;
        longint   off;
        longint   len;
        longint   plen;
        longint   cap;
        longint   filled;
        begin
            off  = c.offset;
            len  = c.length;
            plen = c.msg_len;
            cap  = longint'(capacity_model);
            if (cap > longint'(COUNT_MAX))
                cap = longint'(COUNT_MAX);
            o = '{STATUS_DROP, 1'b0, 31'd0, 1'b0, 16'd0};

            if (c.opcode != TEXT_OPCODE)
                return o;

            if (off < 0 || len < 0 || plen < 0 || !c.data || len == 0 || off + len > plen)
            begin
                msg_expected = '0;
                msg_written  = '0;
                return o;
            end

            // whole message straight from the chunk
            if (off == 0 && len == plen && msg_expected == '0)
            begin
                o.status       = STATUS_READY;
                o.ready_length = 31'(len);
                return o;
            end

            if (off == 0)
            begin
                if (plen > cap)
                begin
                    msg_expected = '0;
                    msg_written  = '0;
                    return o;
                end
                msg_expected = count_t'(plen);
                msg_written  = '0;
            end
            else if (msg_expected == '0 || off != longint'(msg_written))
            begin
                msg_expected = '0;
                msg_written  = '0;
                return o;
            end

            filled = longint'(msg_written) + len;
            if (filled > cap)
            begin
                msg_expected = '0;
                msg_written  = '0;
                return o;
            end

            o.append_enable = 1'b1;
            o.append_offset = 16'(msg_written);
            msg_written     = count_t'(filled);

            if (msg_written < msg_expected)
                o.status = STATUS_MORE;
            else
            begin
                o.status       = STATUS_READY;
                o.from_buffer  = 1'b1;
                o.ready_length = 31'(msg_written);
                msg_expected   = '0;
                msg_written    = '0;
            end
            return o;
        end
    endfunction

    function automatic void queue_chunk(input logic [3:0] op, input logic [31:0] off,
                                        input logic [31:0] len, input logic [31:0] plen,
                                        input logic data);
        chunk_t c;
        begin
            c.opcode  = op;
            c.offset  = off;
            c.length  = len;
            c.msg_len = plen;
            c.data    = data;
            chunk_q.push_back(c);
            items_queued++;
        end
    endfunction

    function automatic logic [3:0] other_opcode();
        int unsigned v;
        begin
            v = $urandom_range(0, 14);
            if (v >= 32'(TEXT_OPCODE))
                v++;
            return 4'(v);
        end
    endfunction

    function automatic void fill_random(input logic [CAP_WIDTH-1:0] cap, input int target);
        int unsigned pick;
        int unsigned plen;
        int unsigned hi;
        int unsigned pos;
        int unsigned step;
        int unsigned idx;
        int unsigned k;
        int          fault;
        logic [31:0] off;
        logic [31:0] clen;
        logic [31:0] mlen;
        logic        data;
        begin
            items_queued = 0;
            while (items_queued < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // fragmented message, sometimes with one broken chunk
                    hi = (cap < 2) ? 40 : cap;
                    if ($urandom_range(0, 19) == 0)
                        plen = cap + $urandom_range(2, 100);
                    else if ($urandom_range(0, 4) != 0)
                        plen = $urandom_range(2, (hi < 256) ? hi : 256);
                    else
                        plen = $urandom_range(2, hi);
                    fault = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 7)) : -1;
                    k     = $urandom_range(0, 3);
                    pos   = 0;
                    idx   = 0;
                    while (pos < plen)
                    begin
                        step = (idx == 0) ? $urandom_range(1, plen - 1)
                                          : $urandom_range(1, plen - pos);
                        off  = pos;
                        clen = step;
                        mlen = plen;
                        data = 1'b1;
                        if (idx > 0 && $urandom_range(0, 3) == 0)
                            mlen = plen + $urandom_range(0, 500);
                        if (idx == k && fault >= 0)
                        begin
                            case (fault)
                                0: off = pos + 1;
                                1: off = (pos != 0) ? pos - 1 : pos + $urandom_range(1, 3);
                                2: data = 1'b0;
                                3: clen = -clen;
                                4: off = '0;
                                5:
                                begin
                                    clen = step + $urandom_range(1, 200);
                                    mlen = pos + clen;
                                end
                                6: mlen = pos + step - 1;
                                default: off = $urandom;
                            endcase
                        end
                        if ($urandom_range(0, 9) == 0)
                            queue_chunk(other_opcode(), $urandom, $urandom, $urandom,
                                        1'($urandom));
                        queue_chunk(TEXT_OPCODE, off, clen, mlen, data);
                        pos += step;
                        idx++;
                    end
                end
                else if (pick < 70)
                begin
                    clen = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 300)
                                                      : $urandom_range(1, 32'h7FFF_FFFF);
                    queue_chunk(TEXT_OPCODE, '0, clen, clen, 1'b1);
                end
                else if (pick < 80)
                    queue_chunk($urandom_range(0, 1) ? TEXT_OPCODE : 4'($urandom),
                                $urandom, $urandom, $urandom, 1'($urandom));
                else if (pick < 93)
                begin
                    off  = $urandom_range(0, 100);
                    clen = $urandom_range(1, 100);
                    mlen = off + clen + $urandom_range(0, 100);
                    data = 1'b1;
                    case ($urandom_range(0, 5))
                        0: off[31] = 1'b1;
                        1: clen[31] = 1'b1;
                        2: mlen[31] = 1'b1;
                        3: clen = '0;
                        4: data = 1'b0;
                        default:
                        begin
                            // end position past the signed 32-bit range, held exactly by the wide sum
                            off  = 32'h7FFF_FFFF - $urandom_range(0, 10);
                            clen = $urandom_range(20, 32'h7FFF_FFFF);
                            mlen = 32'h7FFF_FFFF;
                        end
                    endcase
                    queue_chunk(TEXT_OPCODE, off, clen, mlen, data);
                end
                else
                    queue_chunk(other_opcode(), $urandom, $urandom, $urandom, 1'($urandom));
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        begin
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        end
    endfunction

    // chunk driver
    always @(posedge clk or negedge rst_n)
    begin : drive_chunks
        chunk_t seen;
        chunk_t next_chunk;
        if (!rst_n)
        begin
            chunk_ch.valid          <= 1'b0;
            chunk_ch.opcode         <= '0;
            chunk_ch.chunk_offset   <= '0;
            chunk_ch.chunk_length   <= '0;
            chunk_ch.message_length <= '0;
            chunk_ch.data_present   <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (chunk_ch.valid && chunk_ch.ready)
            begin
                seen.opcode  = chunk_ch.opcode;
                seen.offset  = chunk_ch.chunk_offset;
                seen.length  = chunk_ch.chunk_length;
                seen.msg_len = chunk_ch.message_length;
                seen.data    = chunk_ch.data_present;
                outcome_q.push_back(track_chunk(seen));
            end
            if (!chunk_ch.valid || chunk_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    chunk_ch.valid <= 1'b0;
                end
                else if (chunk_q.size() != 0 && src_idle_pct != 0 &&
                         $urandom_range(0, 99) < src_idle_pct)
                begin
                    src_gap = $urandom_range(0, 7);
                    chunk_ch.valid <= 1'b0;
                end
                else if (chunk_q.size() != 0)
                begin
                    next_chunk = chunk_q.pop_front();
                    chunk_ch.opcode         <= next_chunk.opcode;
                    chunk_ch.chunk_offset   <= next_chunk.offset;
                    chunk_ch.chunk_length   <= next_chunk.length;
                    chunk_ch.message_length <= next_chunk.msg_len;
                    chunk_ch.data_present   <= next_chunk.data;
                    chunk_ch.valid          <= 1'b1;
                end
                else
                    chunk_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin : check_results
        outcome_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result transaction with no chunk waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 32'(want.status), 32'(result_ch.status));
                    check_field("from_buffer", 32'(want.from_buffer),
                                32'(result_ch.from_buffer));
                    check_field("ready_length", 32'(want.ready_length),
                                32'(result_ch.ready_length));
                    check_field("append_enable", 32'(want.append_enable),
                                32'(result_ch.append_enable));
                    check_field("append_offset", 32'(want.append_offset),
                                32'(result_ch.append_offset));
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                result_ch.ready <= 1'b0;
            end
            else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
            begin
                snk_gap = $urandom_range(0, 7);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic run_phase(input logic do_write, input logic [CAP_WIDTH-1:0] cap,
                             input int target, input int src_pct, input int snk_pct);
        begin
            if (do_write)
            begin
                @(posedge clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= cap;
                @(posedge clk);
                cfg_we <= 1'b0;
                capacity_model = cap;
            end
            src_idle_pct = src_pct;
            snk_idle_pct = snk_pct;
            fill_random(capacity_model, target);
            // the next phase waits until every chunk is sent and every result is back
            while (chunk_q.size() != 0 || chunk_ch.valid || outcome_q.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        chunk_ch.valid          = 1'b0;
        chunk_ch.opcode         = '0;
        chunk_ch.chunk_offset   = '0;
        chunk_ch.chunk_length   = '0;
        chunk_ch.message_length = '0;
        chunk_ch.data_present   = 1'b0;
        result_ch.ready         = 1'b0;
        capacity_model          = CAP_RESET;
        msg_expected            = '0;
        msg_written             = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-text frames
        queue_chunk(4'h0, 0, 5, 5, 1'b1);
        queue_chunk(4'hF, 0, 5, 5, 1'b1);
        // whole messages, smallest and largest
        queue_chunk(TEXT_OPCODE, 0, 1, 1, 1'b1);
        queue_chunk(TEXT_OPCODE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // bad descriptors
        queue_chunk(TEXT_OPCODE, 32'hFFFF_FFFF, 1, 10, 1'b1);
        queue_chunk(TEXT_OPCODE, 0, 32'h8000_0000, 10, 1'b1);
        queue_chunk(TEXT_OPCODE, 0, 1, 32'h8000_0000, 1'b1);
        queue_chunk(TEXT_OPCODE, 0, 0, 10, 1'b1);
        queue_chunk(TEXT_OPCODE, 0, 5, 5, 1'b0);
        queue_chunk(TEXT_OPCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // oversize for the reset capacity
        queue_chunk(TEXT_OPCODE, 0, 10, 4097, 1'b1);
        // fragment, ignored frame in between, continuation with another length
        queue_chunk(TEXT_OPCODE, 0, 100, 300, 1'b1);
        queue_chunk(4'h2, 0, 1, 1, 1'b1);
        queue_chunk(TEXT_OPCODE, 100, 100, 999, 1'b1);
        // restart while busy, then a gap, then a continuation while idle
        queue_chunk(TEXT_OPCODE, 0, 50, 60, 1'b1);
        queue_chunk(TEXT_OPCODE, 51, 5, 60, 1'b1);
        queue_chunk(TEXT_OPCODE, 10, 5, 60, 1'b1);
        // overlap
        queue_chunk(TEXT_OPCODE, 0, 10, 20, 1'b1);
        queue_chunk(TEXT_OPCODE, 5, 5, 20, 1'b1);
        // fills the buffer exactly
        queue_chunk(TEXT_OPCODE, 0, 4000, 4096, 1'b1);
        queue_chunk(TEXT_OPCODE, 4000, 96, 4096, 1'b1);
        // one byte past capacity
        queue_chunk(TEXT_OPCODE, 0, 4000, 4096, 1'b1);
        queue_chunk(TEXT_OPCODE, 4000, 97, 5000, 1'b1);
        // whole message while busy goes through the buffer
        queue_chunk(TEXT_OPCODE, 0, 10, 20, 1'b1);
        queue_chunk(TEXT_OPCODE, 0, 20, 20, 1'b1);
        // written count passes the expected total
        queue_chunk(TEXT_OPCODE, 0, 10, 20, 1'b1);
        queue_chunk(TEXT_OPCODE, 10, 30, 40, 1'b1);

        run_phase(1'b0, CAP_RESET, 150, 10, 10);
        run_phase(1'b1, 16'hFFFF, 150, 25, 5);
        run_phase(1'b1, 16'd0, 100, 5, 25);
        run_phase(1'b1, 16'd1, 100, 10, 10);
        run_phase(1'b1, 16'($urandom_range(2, 2000)), 150, 0, 30);
        run_phase(1'b1, 16'd300, 150, 30, 0);
        run_phase(1'b1, 16'($urandom), 150, 10, 10);
        run_phase(1'b1, CAP_RESET, 200, 0, 0);

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("websocket_fragment_reassembly_tracker_unit verification clean");
        else
            $display("websocket_fragment_reassembly_tracker_unit verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("websocket_fragment_reassembly_tracker_unit verification failed");
        $finish;
    end

endmodule
